// ----- rtl/mxt_pkg.sv -----
// Shared types and constants of the maximum-XOR trie core.
// Used by mxt_link_store and max_xor_pair_trie_core; depends on nothing.
package mxt_pkg;

    // Default sizing of the trie.
    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_MAX_ITEMS  = 1024;

    // Fixed widths of the input value and of the reported results.
    localparam int IN_W  = 32;
    localparam int RES_W = 32;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_QUERY,
        ST_INSERT,
        ST_ALLOC
    } mxt_state_t;

    // Write request control toward the link store.
    typedef struct packed {
        logic en;
        logic to_root;
    } mxt_wr_ctl_t;

endpackage

// ----- rtl/mxt_link_store.sv -----
// Child link storage of the trie: root links in flip-flops, other nodes in a memory.
// Depends on mxt_pkg for the write control struct.
module mxt_link_store
    import mxt_pkg::*;
#(
    parameter int NODE_SLOTS = DEF_MAX_ITEMS * DEF_VALUE_BITS + 1,
    parameter int NW         = $clog2(NODE_SLOTS)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   root_clear,
    input  logic [NW-1:0]          rd_addr,
    input  logic                   rd_root,
    input  mxt_wr_ctl_t            wr_ctl,
    input  logic [NW-1:0]          wr_addr,
    input  logic [1:0][NW-1:0]     wr_links,
    output logic [1:0][NW-1:0]     cur_links
);

    logic [1:0][NW-1:0] mem [NODE_SLOTS];
    logic [1:0][NW-1:0] root_reg;
    logic [1:0][NW-1:0] rdata_reg;
    logic               rd_root_reg;

    // Root links are cleared at reset and when a new set starts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg    <= '0;
            rd_root_reg <= 1'b1;
        end
        else
        begin
            rd_root_reg <= rd_root;
            if (root_clear)
            begin
                root_reg <= '0;
            end
            else if (wr_ctl.en && wr_ctl.to_root)
            begin
                root_reg <= wr_links;
            end
        end
    end

    // Node memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_ctl.en && !wr_ctl.to_root)
        begin
            mem[wr_addr] <= wr_links;
        end
        rdata_reg <= mem[rd_addr];
    end

    // The links of the node being visited come from the root or from the memory.
    assign cur_links = rd_root_reg ? root_reg : rdata_reg;

endmodule

// ----- rtl/max_xor_pair_trie_core.sv -----
// Each item runs a query walk with one trie read per level (skipped for the first item
// of a set or an empty set), an insert walk with one read per level, then one memory
// write per newly allocated node, and ends with the done strobe.
// busy stays high for the whole item; the next item is taken in the done cycle.
// Reset clears the root links, node count, running maximum and set state; the node
// memory needs no clearing because a node's links are written when it is allocated.
module max_xor_pair_trie_core
    import mxt_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_ITEMS  = DEF_MAX_ITEMS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [IN_W-1:0]  value,
    input  logic             first,
    output logic             done,
    output logic [RES_W-1:0] best_xor,
    output logic [RES_W-1:0] running_max,
    output logic             had_partner,
    output logic             store_full
);

    localparam int NODE_SLOTS = MAX_ITEMS * VALUE_BITS + 1;
    localparam int NW         = $clog2(NODE_SLOTS);
    localparam int LW         = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    mxt_state_t              state_reg, state_next;
    logic [LW-1:0]           lvl_reg, lvl_next;
    logic [NW-1:0]           node_reg, node_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic [NW-1:0]           count_reg, count_next;
    logic [RES_W-1:0]        best_reg, best_next;
    logic                    nonempty_reg, nonempty_next;
    logic                    partner_reg, partner_next;
    logic                    done_reg, done_next;
    logic [RES_W-1:0]        xor_out_reg, xor_out_next;
    logic                    full_out_reg, full_out_next;
    logic                    partner_out_reg, partner_out_next;

    logic                    root_clear;
    logic [NW-1:0]           rd_addr;
    logic                    rd_root;
    mxt_wr_ctl_t             wr_ctl;
    logic [NW-1:0]           wr_addr;
    logic [1:0][NW-1:0]      wr_links;
    logic [1:0][NW-1:0]      cur_links;

    logic                    accept;
    logic                    bit_cur;
    logic                    bit_below;
    logic [LW-1:0]           lvl_dn;
    logic [NW-1:0]           link_same;
    logic [NW-1:0]           link_other;
    logic [NW:0]             need_nodes;
    logic                    no_room;
    logic                    finish;
    logic                    finish_full;
    logic [VALUE_BITS+IN_W-1:0]  val_wide;
    logic [VALUE_BITS+RES_W-1:0] acc_wide;
    logic [RES_W-1:0]        found;

    mxt_link_store #(
        .NODE_SLOTS (NODE_SLOTS),
        .NW         (NW)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .root_clear (root_clear),
        .rd_addr    (rd_addr),
        .rd_root    (rd_root),
        .wr_ctl     (wr_ctl),
        .wr_addr    (wr_addr),
        .wr_links   (wr_links),
        .cur_links  (cur_links)
    );

    // Level decode shared by the query, insert and allocation steps.
    assign accept     = start && (state_reg == ST_IDLE);
    assign lvl_dn     = lvl_reg - 1'b1;
    assign bit_cur    = val_reg[lvl_reg];
    assign bit_below  = val_reg[lvl_dn];
    assign link_same  = cur_links[bit_cur];
    assign link_other = cur_links[~bit_cur];
    assign need_nodes = {1'b0, count_reg} + (NW+1)'(lvl_reg) + 1'b1;
    assign no_room    = need_nodes > (NW+1)'(NODE_SLOTS - 1);
    assign val_wide   = {{VALUE_BITS{1'b0}}, value};
    assign acc_wide   = {{RES_W{1'b0}}, acc_reg};
    assign found      = acc_wide[RES_W-1:0];

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (nonempty_reg && !first) ? ST_QUERY : ST_INSERT;
                end
            end
            ST_QUERY:
            begin
                if (lvl_reg == '0 || (link_same == '0 && link_other == '0))
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (link_same == '0)
                begin
                    state_next = no_room ? ST_IDLE : ST_ALLOC;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ALLOC:
            begin
                if (lvl_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and register updates for each state.
    always_comb
    begin
        lvl_next         = lvl_reg;
        node_next        = node_reg;
        val_next         = val_reg;
        acc_next         = acc_reg;
        count_next       = count_reg;
        best_next        = best_reg;
        nonempty_next    = nonempty_reg;
        partner_next     = partner_reg;
        root_clear       = 1'b0;
        rd_addr          = '0;
        rd_root          = 1'b0;
        wr_ctl           = '0;
        wr_addr          = '0;
        wr_links         = '0;
        finish           = 1'b0;
        finish_full      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                rd_root = 1'b1;
                if (accept)
                begin
                    val_next     = val_wide[VALUE_BITS-1:0];
                    acc_next     = '0;
                    lvl_next     = LW'(VALUE_BITS - 1);
                    node_next    = '0;
                    partner_next = nonempty_reg && !first;
                    if (first)
                    begin
                        root_clear    = 1'b1;
                        count_next    = '0;
                        best_next     = '0;
                        nonempty_next = 1'b0;
                    end
                end
            end
            ST_QUERY:
            begin
                // Prefer the branch whose bit differs from the value's bit.
                if (link_other != '0)
                begin
                    acc_next[lvl_reg] = 1'b1;
                    rd_addr           = link_other;
                end
                else
                begin
                    rd_addr = link_same;
                end
                if (lvl_reg == '0 || (link_same == '0 && link_other == '0))
                begin
                    rd_root   = 1'b1;
                    lvl_next  = LW'(VALUE_BITS - 1);
                    node_next = '0;
                end
                else
                begin
                    lvl_next = lvl_dn;
                end
            end
            ST_INSERT:
            begin
                rd_addr = link_same;
                if (link_same == '0)
                begin
                    if (no_room)
                    begin
                        finish      = 1'b1;
                        finish_full = 1'b1;
                    end
                    else
                    begin
                        // Hook the first new node onto the last existing node.
                        wr_ctl.en          = 1'b1;
                        wr_ctl.to_root     = (node_reg == '0);
                        wr_addr            = node_reg;
                        wr_links           = cur_links;
                        wr_links[bit_cur]  = count_reg + 1'b1;
                    end
                end
                else if (lvl_reg == '0)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    node_next = link_same;
                    lvl_next  = lvl_dn;
                end
            end
            ST_ALLOC:
            begin
                // Each new node gets cleared links, chained to the next new node except at level 0.
                wr_ctl.en      = 1'b1;
                wr_ctl.to_root = 1'b0;
                wr_addr        = count_reg + 1'b1;
                if (lvl_reg != '0)
                begin
                    wr_links[bit_below] = count_reg + 2'd2;
                end
                count_next = count_reg + 1'b1;
                if (lvl_reg == '0)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    lvl_next = lvl_dn;
                end
            end
            default:
            begin
                rd_root = 1'b1;
            end
        endcase

        // Result capture when the item completes.
        done_next        = finish;
        xor_out_next     = xor_out_reg;
        full_out_next    = full_out_reg;
        partner_out_next = partner_out_reg;
        if (finish)
        begin
            xor_out_next     = found;
            full_out_next    = finish_full;
            partner_out_next = partner_reg;
            if (found > best_reg)
            begin
                best_next = found;
            end
            if (!finish_full)
            begin
                nonempty_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            best_reg     <= '0;
            nonempty_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            best_reg     <= best_next;
            nonempty_reg <= nonempty_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        lvl_reg         <= lvl_next;
        node_reg        <= node_next;
        val_reg         <= val_next;
        acc_reg         <= acc_next;
        partner_reg     <= partner_next;
        xor_out_reg     <= xor_out_next;
        full_out_reg    <= full_out_next;
        partner_out_reg <= partner_out_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign best_xor    = xor_out_reg;
    assign running_max = best_reg;
    assign had_partner = partner_out_reg;
    assign store_full  = full_out_reg;

endmodule
